// ===== hdl/laser_scan_motion_segmenter_defines.svh =====
// Assertion macros for the laser scan motion segmenter.
// Included by the checker; needs nothing else.
`ifndef LASER_SCAN_MOTION_SEGMENTER_DEFINES_SVH
`define LASER_SCAN_MOTION_SEGMENTER_DEFINES_SVH

// same-cycle implication
`define LSMS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lsms assertion failed");

// next-cycle implication
`define LSMS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lsms assertion failed");

`endif

// ===== hdl/lsms_pkg.sv =====
// Shared types and constants of the laser scan motion segmenter.
// No dependencies.
`default_nettype none
package lsms_pkg;
   localparam int unsigned MAX_BEAMS = 1024;
   localparam int unsigned IDX_W     = $clog2(MAX_BEAMS);
   localparam int unsigned RANGE_W   = 16;
   localparam int unsigned COORD_W   = 16;
   localparam int unsigned CNT_W     = 11;
   localparam int unsigned LEN_W     = IDX_W + 1;
   localparam int unsigned PCT_W     = 7;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned DIV_W     = 18;
   localparam int unsigned DIV_CNT_W = 5;
   localparam int unsigned SQ_W      = 32;

   localparam logic [CNT_W-1:0]   DYN_MAX    = '1;
   localparam logic [IDX_W-1:0]   IDX_LAST   = IDX_W'(MAX_BEAMS - 1);
   localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(DIV_W);
   localparam logic [PCT_W-1:0]   PCT_FULL   = PCT_W'(100);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FLOOR, REG_CEILING, REG_MOTION, REG_GAP, REG_LEG_MIN, REG_LEG_MAX, REG_DYN_PCT
   } csr_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOAD, ST_GAP_X, ST_GAP_Y, ST_UPDATE,
      ST_SIZE_X, ST_SIZE_Y, ST_DIV, ST_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic load;
      logic gap_x;
      logic gap_y;
      logic update;
      logic size_x;
      logic size_y;
      logic div_step;
      logic is_final;
   } dp_cmd_type;

   typedef struct packed {
      logic first;
      logic last;
      logic split;
      logic div_done;
   } dp_status_type;
endpackage
`default_nettype wire

// ===== hdl/lsms_if.sv =====
// Channel interfaces: beam input, cluster result and register write.
// Uses lsms_pkg for widths.
`default_nettype none
interface lsms_req_if;
   logic                              valid;
   logic                              ready;
   logic [lsms_pkg::RANGE_W-1:0]      range_mm;
   logic signed [lsms_pkg::COORD_W-1:0] x_mm;
   logic signed [lsms_pkg::COORD_W-1:0] y_mm;
   logic                              moving;
   logic                              first_beam;
   logic                              last_beam;
   modport source (output valid, range_mm, x_mm, y_mm, moving, first_beam, last_beam,
                   input ready);
   modport sink (input valid, range_mm, x_mm, y_mm, moving, first_beam, last_beam,
                 output ready);
endinterface

interface lsms_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [lsms_pkg::IDX_W-1:0]        start_index;
   logic [lsms_pkg::IDX_W-1:0]        end_index;
   logic signed [lsms_pkg::COORD_W-1:0] middle_x_mm;
   logic signed [lsms_pkg::COORD_W-1:0] middle_y_mm;
   logic [lsms_pkg::PCT_W-1:0]        dynamic_percent;
   logic                              is_leg;
   logic                              leg_moving;
   logic                              last_of_scan;
   modport source (output valid, start_index, end_index, middle_x_mm, middle_y_mm,
                   dynamic_percent, is_leg, leg_moving, last_of_scan, input ready);
   modport sink (input valid, start_index, end_index, middle_x_mm, middle_y_mm,
                 dynamic_percent, is_leg, leg_moving, last_of_scan, output ready);
endinterface

interface lsms_csr_if;
   logic                              valid;
   logic                              ready;
   logic [lsms_pkg::CSR_IDX_W-1:0]    index;
   logic [lsms_pkg::RANGE_W-1:0]      data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/laser_scan_motion_segmenter.sv =====
// Beam in scan order: range, x, y, robot_moving, first_beam, last_beam.
// Result: one closed cluster with indices, midpoint, dynamic percent, leg flags.
// Channels: req_ch takes beams, rsp_ch gives clusters, csr_ch writes the
// seven registers by index (always ready). Each handshake moves one item
// when valid and ready are both high at a rising clock edge.
// One beam is worked at a time; req_ch.ready is high only between beams.
// A beam that closes no cluster goes through load, both gap halves and update before ready returns.
// Each result adds the size, divider and output states and any stall on rsp_ch;
// a beam gives at most two results (the cluster closed by a gap, then the final
// one on last_beam), built with the 18-step percentage divider and shared squarer.
// A stalled result is held in registers; no new beam is taken meanwhile.
// Synchronous active-high reset restores register defaults and scan state.
// The background store is not cleared by reset; it is read at every beam, written only while storing.
// Uses lsms_pkg, lsms_if, lsms_ctrl, lsms_dp.
`default_nettype none
module laser_scan_motion_segmenter (
   input  wire logic  clock,
   input  wire logic  reset,
   lsms_req_if.sink   req_ch,
   lsms_rsp_if.source rsp_ch,
   lsms_csr_if.sink   csr_ch
);
   lsms_pkg::dp_cmd_type    cmd;
   lsms_pkg::dp_status_type status;

   lsms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   lsms_dp u_dp (
      .clock  (clock),
      .reset  (reset),
      .req    (req_ch),
      .rsp    (rsp_ch),
      .csr    (csr_ch),
      .cmd    (cmd),
      .status (status)
   );
endmodule
`default_nettype wire

// ===== hdl/lsms_ctrl.sv =====
// Sequencer of the segmenter: walks one beam through load, gap test,
// cluster update and result build. Uses lsms_pkg.
`default_nettype none
module lsms_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   input  wire lsms_pkg::dp_status_type status,
   output lsms_pkg::dp_cmd_type         cmd
);
   lsms_pkg::ctrl_state_type state_ff, state_in;
   logic final_ff, final_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lsms_pkg::ST_IDLE;
         final_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         final_ff <= final_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      final_in = final_ff;
      unique case (state_ff)
         lsms_pkg::ST_IDLE: if (req_valid) state_in = lsms_pkg::ST_LOAD;
         lsms_pkg::ST_LOAD: state_in = lsms_pkg::ST_GAP_X;
         lsms_pkg::ST_GAP_X: state_in = lsms_pkg::ST_GAP_Y;
         lsms_pkg::ST_GAP_Y: begin
            priority if (status.first) begin
               state_in = lsms_pkg::ST_UPDATE;
            end else if (status.split) begin
               state_in = lsms_pkg::ST_SIZE_X;
               final_in = 1'b0;
            end else begin
               state_in = lsms_pkg::ST_UPDATE;
            end
         end
         lsms_pkg::ST_UPDATE: begin
            final_in = 1'b1;
            state_in = status.last ? lsms_pkg::ST_SIZE_X : lsms_pkg::ST_IDLE;
         end
         lsms_pkg::ST_SIZE_X: state_in = lsms_pkg::ST_SIZE_Y;
         lsms_pkg::ST_SIZE_Y: state_in = lsms_pkg::ST_DIV;
         lsms_pkg::ST_DIV: if (status.div_done) state_in = lsms_pkg::ST_OUT;
         lsms_pkg::ST_OUT: begin
            if (rsp_ready) state_in = final_ff ? lsms_pkg::ST_IDLE : lsms_pkg::ST_UPDATE;
         end
         default: state_in = lsms_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = (state_ff == lsms_pkg::ST_IDLE);
      rsp_valid    = (state_ff == lsms_pkg::ST_OUT);
      cmd.accept   = (state_ff == lsms_pkg::ST_IDLE) && req_valid;
      cmd.load     = (state_ff == lsms_pkg::ST_LOAD);
      cmd.gap_x    = (state_ff == lsms_pkg::ST_GAP_X);
      cmd.gap_y    = (state_ff == lsms_pkg::ST_GAP_Y);
      cmd.update   = (state_ff == lsms_pkg::ST_UPDATE);
      cmd.size_x   = (state_ff == lsms_pkg::ST_SIZE_X);
      cmd.size_y   = (state_ff == lsms_pkg::ST_SIZE_Y);
      cmd.div_step = (state_ff == lsms_pkg::ST_DIV) && !status.div_done;
      cmd.is_final = final_ff;
   end
endmodule
`default_nettype wire

// ===== hdl/lsms_dp.sv =====
// Datapath of the segmenter: registers, background store, shared squarer,
// percentage divider and result fields. Uses lsms_pkg and lsms_if.
`default_nettype none
module lsms_dp (
   input  wire logic                 clock,
   input  wire logic                 reset,
   lsms_req_if.sink                  req,
   lsms_rsp_if.source                rsp,
   lsms_csr_if.sink                  csr,
   input  wire lsms_pkg::dp_cmd_type cmd,
   output lsms_pkg::dp_status_type   status
);
   localparam int unsigned RW = lsms_pkg::RANGE_W;
   localparam int unsigned CW = lsms_pkg::COORD_W;
   localparam int unsigned IW = lsms_pkg::IDX_W;

   // configuration
   logic [RW-1:0] floor_ff, ceiling_ff, motion_ff;
   logic [lsms_pkg::PCT_W-1:0] dyn_thr_ff;
   logic [lsms_pkg::SQ_W-1:0] gap2_ff, min2_ff, max2_ff;
   logic [lsms_pkg::SQ_W-1:0] csr_sq;

   assign csr.ready = 1'b1;
   assign csr_sq = {{RW{1'b0}}, csr.data} * {{RW{1'b0}}, csr.data};

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff   <= RW'(0);
         ceiling_ff <= RW'(30000);
         motion_ff  <= RW'(200);
         dyn_thr_ff <= lsms_pkg::PCT_W'(75);
         gap2_ff    <= lsms_pkg::SQ_W'(40000);
         min2_ff    <= lsms_pkg::SQ_W'(2500);
         max2_ff    <= lsms_pkg::SQ_W'(62500);
      end else if (csr.valid) begin
         unique case (lsms_pkg::csr_reg_type'(csr.index))
            lsms_pkg::REG_FLOOR:   floor_ff   <= csr.data;
            lsms_pkg::REG_CEILING: ceiling_ff <= csr.data;
            lsms_pkg::REG_MOTION:  motion_ff  <= csr.data;
            lsms_pkg::REG_GAP:     gap2_ff    <= csr_sq;
            lsms_pkg::REG_LEG_MIN: min2_ff    <= csr_sq;
            lsms_pkg::REG_LEG_MAX: max2_ff    <= csr_sq;
            lsms_pkg::REG_DYN_PCT: dyn_thr_ff <= csr.data[lsms_pkg::PCT_W-1:0];
            default: ;
         endcase
      end
   end

   // captured item
   logic [RW-1:0] range_ff;
   logic signed [CW-1:0] x_ff, y_ff;
   logic moving_ff, first_ff, last_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         range_ff  <= req.range_mm;
         x_ff      <= req.x_mm;
         y_ff      <= req.y_mm;
         moving_ff <= req.moving;
         first_ff  <= req.first_beam;
         last_ff   <= req.last_beam;
      end
   end

   // scan state
   logic [IW-1:0] beam_index_ff, idx_ff, prev_index_ff, start_beam_ff;
   logic prev_moving_ff, storing_ff;
   logic signed [CW-1:0] last_x_ff, last_y_ff, start_x_ff, start_y_ff;
   logic [lsms_pkg::CNT_W-1:0] dyn_cnt_ff;
   logic [RW-1:0] r_ff;
   logic split_ff;

   logic [IW-1:0] idx_in;
   logic [RW-1:0] r_in;
   logic storing_in;

   assign idx_in     = first_ff ? IW'(0) : beam_index_ff;
   assign r_in       = (range_ff < ceiling_ff && range_ff > floor_ff) ? range_ff : ceiling_ff;
   assign storing_in = first_ff ? (prev_moving_ff && !moving_ff) : storing_ff;

   // background store
   logic [RW-1:0] bg_mem [lsms_pkg::MAX_BEAMS];
   logic [RW-1:0] bg_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         if (storing_in) bg_mem[idx_in] <= r_in;
         bg_rd_ff <= bg_mem[idx_in];
      end
   end

   // storing beams read the old stored range and are never flagged dynamic
   logic signed [RW+1:0] bg_diff;
   logic dyn, dyn_ff;
   assign bg_diff = $signed({2'b00, bg_rd_ff}) - $signed({2'b00, r_ff});
   assign dyn = !moving_ff && !storing_ff && (bg_diff > $signed({2'b00, motion_ff}));

   // shared squarer
   logic signed [CW:0] mul_a;
   logic signed [2*CW+1:0] prod;
   logic [lsms_pkg::SQ_W-1:0] sq, acc_ff;
   logic [lsms_pkg::SQ_W:0] sum, size2_ff;

   always_comb begin
      priority if (cmd.gap_x)  mul_a = {last_x_ff[CW-1], last_x_ff} - {x_ff[CW-1], x_ff};
      else if (cmd.gap_y)      mul_a = {last_y_ff[CW-1], last_y_ff} - {y_ff[CW-1], y_ff};
      else if (cmd.size_x)     mul_a = {start_x_ff[CW-1], start_x_ff} - {last_x_ff[CW-1], last_x_ff};
      else                     mul_a = {start_y_ff[CW-1], start_y_ff} - {last_y_ff[CW-1], last_y_ff};
   end
   assign prod = (2*CW+2)'(mul_a) * (2*CW+2)'(mul_a);
   assign sq   = prod[lsms_pkg::SQ_W-1:0];
   assign sum  = {1'b0, acc_ff} + {1'b0, sq};

   // percentage divider
   logic [lsms_pkg::DIV_W-1:0] quo_ff;
   logic [lsms_pkg::LEN_W-1:0] rem_ff, len_ff, len_in;
   logic [lsms_pkg::LEN_W:0] trial;
   logic [lsms_pkg::DIV_CNT_W-1:0] div_cnt_ff;
   logic [lsms_pkg::DIV_W-1:0] dvd_in, cnt_ext;

   assign cnt_ext = lsms_pkg::DIV_W'(dyn_cnt_ff);
   assign dvd_in  = (cnt_ext << 6) + (cnt_ext << 5) + (cnt_ext << 2);
   assign len_in  = (prev_index_ff >= start_beam_ff)
                  ? lsms_pkg::LEN_W'(prev_index_ff - start_beam_ff) + lsms_pkg::LEN_W'(1)
                  : lsms_pkg::LEN_W'(1);
   assign trial   = {rem_ff, quo_ff[lsms_pkg::DIV_W-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         beam_index_ff  <= '0;
         prev_index_ff  <= '0;
         prev_moving_ff <= 1'b1;
         storing_ff     <= 1'b0;
         last_x_ff      <= '0;
         last_y_ff      <= '0;
         start_x_ff     <= '0;
         start_y_ff     <= '0;
         start_beam_ff  <= '0;
         dyn_cnt_ff     <= '0;
         div_cnt_ff     <= '0;
      end else begin
         if (cmd.load) begin
            idx_ff <= idx_in;
            r_ff   <= r_in;
            if (first_ff) begin
               storing_ff     <= storing_in;
               prev_moving_ff <= moving_ff;
            end
         end
         if (cmd.gap_x) acc_ff <= sq;
         if (cmd.gap_y) dyn_ff <= dyn;
         if (cmd.size_x) begin
            acc_ff     <= sq;
            quo_ff     <= dvd_in;
            rem_ff     <= '0;
            len_ff     <= len_in;
            div_cnt_ff <= '0;
         end
         if (cmd.size_y) size2_ff <= sum;
         if (cmd.div_step) begin
            div_cnt_ff <= div_cnt_ff + lsms_pkg::DIV_CNT_W'(1);
            if (trial >= {1'b0, len_ff}) begin
               rem_ff <= lsms_pkg::LEN_W'(trial - {1'b0, len_ff});
               quo_ff <= {quo_ff[lsms_pkg::DIV_W-2:0], 1'b1};
            end else begin
               rem_ff <= trial[lsms_pkg::LEN_W-1:0];
               quo_ff <= {quo_ff[lsms_pkg::DIV_W-2:0], 1'b0};
            end
         end
         if (cmd.update) begin
            if (first_ff || split_ff) begin
               start_beam_ff <= idx_ff;
               start_x_ff    <= x_ff;
               start_y_ff    <= y_ff;
               dyn_cnt_ff    <= lsms_pkg::CNT_W'(dyn_ff);
            end else if (dyn_ff && dyn_cnt_ff != lsms_pkg::DYN_MAX) begin
               dyn_cnt_ff <= dyn_cnt_ff + lsms_pkg::CNT_W'(1);
            end
            last_x_ff     <= x_ff;
            last_y_ff     <= y_ff;
            prev_index_ff <= idx_ff;
            beam_index_ff <= (idx_ff == lsms_pkg::IDX_LAST) ? idx_ff : idx_ff + IW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.gap_y) split_ff <= (sum >= {1'b0, gap2_ff});
   end

   assign status.first    = first_ff;
   assign status.last     = last_ff;
   assign status.split    = (sum >= {1'b0, gap2_ff});
   assign status.div_done = (div_cnt_ff == lsms_pkg::DIV_STEPS);

   // result fields, held from registers while the result waits
   logic signed [CW:0] mid_x, mid_y;
   logic [lsms_pkg::PCT_W-1:0] pct;
   logic leg;

   assign mid_x = {start_x_ff[CW-1], start_x_ff} + {last_x_ff[CW-1], last_x_ff};
   assign mid_y = {start_y_ff[CW-1], start_y_ff} + {last_y_ff[CW-1], last_y_ff};
   assign pct   = (quo_ff > lsms_pkg::DIV_W'(lsms_pkg::PCT_FULL))
                ? lsms_pkg::PCT_FULL : quo_ff[lsms_pkg::PCT_W-1:0];
   assign leg   = (size2_ff > {1'b0, min2_ff}) && (size2_ff < {1'b0, max2_ff});

   assign rsp.start_index     = start_beam_ff;
   assign rsp.end_index       = prev_index_ff;
   assign rsp.middle_x_mm     = mid_x[CW:1];
   assign rsp.middle_y_mm     = mid_y[CW:1];
   assign rsp.dynamic_percent = pct;
   assign rsp.is_leg          = leg;
   assign rsp.leg_moving      = leg && (pct > dyn_thr_ff);
   assign rsp.last_of_scan    = cmd.is_final;
endmodule
`default_nettype wire

// ===== hdl/lsms_checker.sv =====
// Port-level checks of the segmenter, bound to the top level.
// Uses laser_scan_motion_segmenter_defines.svh.
`default_nettype none
`include "laser_scan_motion_segmenter_defines.svh"
module lsms_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_ready,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic [lsms_pkg::IDX_W-1:0]     rsp_start_index,
   input wire logic [lsms_pkg::IDX_W-1:0]     rsp_end_index,
   input wire logic [lsms_pkg::PCT_W-1:0]     rsp_dynamic_percent,
   input wire logic                           rsp_is_leg,
   input wire logic                           rsp_leg_moving
);
   `LSMS_ASSERT_NEXT(a_busy_after_item, clock, reset, req_valid && req_ready, !req_ready)
   `LSMS_ASSERT_SAME(a_no_take_while_out, clock, reset, rsp_valid, !req_ready)
   `LSMS_ASSERT_SAME(a_pct_range, clock, reset, rsp_valid, rsp_dynamic_percent <= lsms_pkg::PCT_FULL)
   `LSMS_ASSERT_SAME(a_moving_is_leg, clock, reset, rsp_valid && rsp_leg_moving, rsp_is_leg)
   `LSMS_ASSERT_NEXT(a_hold_stalled, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_start_index) && $stable(rsp_end_index))
endmodule

bind laser_scan_motion_segmenter lsms_checker u_lsms_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_ch.valid),
   .req_ready           (req_ch.ready),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .rsp_start_index     (rsp_ch.start_index),
   .rsp_end_index       (rsp_ch.end_index),
   .rsp_dynamic_percent (rsp_ch.dynamic_percent),
   .rsp_is_leg          (rsp_ch.is_leg),
   .rsp_leg_moving      (rsp_ch.leg_moving)
);
`default_nettype wire
